>>> design/bls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants for the bounded stack: item layouts, opcodes,
// status codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package bls_pkg;

	// Storage geometry.
	localparam int DEPTH       = 8;
	localparam int MAX_RESULTS = 8;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int CAP_W       = 4;
	localparam int POS_W       = 4;
	localparam int WORD_W      = 32;
	localparam int K_W         = $clog2(MAX_RESULTS);
	localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int CAP_RESET   = 8;

	// Opcodes.
	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_POP  = 3'd1;
	localparam logic [2:0] OP_PEEK = 3'd2;
	localparam logic [2:0] OP_READ = 3'd3;
	localparam logic [2:0] OP_DUMP = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_BADPOS = 2'd3;

	typedef struct packed {
		logic [2:0]               opcode;
		logic signed [WORD_W-1:0] push_value;
		logic [POS_W-1:0]         position;
	} in_item_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] read_value;
		logic                     last_of_run;
		logic                     is_empty;
		logic                     is_full;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic emit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic no_result;
		logic more;
		logic out_busy;
	} dp_sts_t;

endpackage
`default_nettype wire

>>> design/bls_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bls_ram
// Generic simple dual-port RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> design/bls_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bls_ctrl
// Controller for the stack: takes an item, runs the execute step, then emits
// one result or a run of results for a dump (none for unused opcodes or an empty dump).
// ----------------------------------------------------------------------------
module bls_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire bls_pkg::dp_sts_t  sts,
	output bls_pkg::ctrl_cmd_t     cmd
);
	import bls_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.no_result ? S_IDLE : S_EMIT;
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					if (!sts.more) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// An accepted item always moves on to the execute step.
	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_EXEC))
		else $error("accepted item did not reach execute");

	// The execute step lasts exactly one cycle.
	a_exec_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> (state_q != S_EXEC))
		else $error("execute step repeated");

	// A result is only emitted while the output side can take it.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.out_busy)
		else $error("emit while output register is held");

endmodule
`default_nettype wire

>>> design/bls_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bls_dp
// Datapath for the stack: item registers, entry count, capacity register,
// word memory, dump index and the output register.
// ----------------------------------------------------------------------------
module bls_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire bls_pkg::in_item_t            in_item,
	input  wire logic                         cfg_wr_en,
	input  wire logic [bls_pkg::CAP_W-1:0]    cfg_wr_data,
	input  wire bls_pkg::ctrl_cmd_t           cmd,
	output bls_pkg::dp_sts_t                  sts,
	input  wire logic                         out_stall,
	output logic                              out_valid,
	output bls_pkg::out_item_t                out_item
);
	import bls_pkg::*;

	logic [2:0]               op_q;
	logic signed [WORD_W-1:0] val_q;
	logic [POS_W-1:0]         pos_q;
	logic [CNT_W-1:0]         count_q;
	logic [CAP_W-1:0]         cap_q;
	logic [K_W-1:0]           k_q;
	logic [1:0]               res_st_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic [CMP_W-1:0]  count_c;
	logic [CMP_W-1:0]  cap_c;
	logic [CMP_W-1:0]  cap_eff;
	logic [CMP_W-1:0]  pos_c;
	logic [CMP_W-1:0]  n_c;
	logic              full;
	logic              empty;
	logic              pos_bad;
	logic              last;
	logic [ADDR_W-1:0] top_addr;
	logic [ADDR_W-1:0] pos_addr;
	logic [ADDR_W-1:0] next_addr;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ADDR_W-1:0] mem_raddr;
	logic [WORD_W-1:0] mem_rdata;

	// Effective capacity, fill flags and position check.
	always_comb begin
		count_c = CMP_W'(count_q);
		cap_c   = CMP_W'(cap_q);
		pos_c   = CMP_W'(pos_q);
		if (cap_c == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_c > CMP_W'(DEPTH)) begin
			cap_eff = CMP_W'(DEPTH);
		end else begin
			cap_eff = cap_c;
		end
		full    = (count_c >= cap_eff);
		empty   = (count_q == '0);
		pos_bad = (pos_q == '0) || (pos_c > count_c);
		n_c     = (count_c > CMP_W'(MAX_RESULTS)) ? CMP_W'(MAX_RESULTS) : count_c;
		last    = ((CMP_W'(k_q) + CMP_W'(1)) == n_c);
	end

	// Memory addresses: the top, a position below it, and the next dump entry.
	assign top_addr  = ADDR_W'(count_c - CMP_W'(1));
	assign pos_addr  = ADDR_W'(count_c - pos_c);
	assign next_addr = ADDR_W'(count_c - CMP_W'(k_q) - CMP_W'(2));
	assign mem_waddr = ADDR_W'(count_c);

	// Memory access for the execute step and for each further dump entry.
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = top_addr;
		if (cmd.exec) begin
			case (op_q)
				OP_PUSH: mem_we = !full;
				OP_POP:  mem_re = !empty;
				OP_PEEK: mem_re = !empty;
				OP_READ: begin
					mem_re    = !pos_bad;
					mem_raddr = pos_addr;
				end
				OP_DUMP: mem_re = !empty;
				default: mem_re = 1'b0;
			endcase
		end
		if (cmd.emit && sts.more) begin
			mem_re    = 1'b1;
			mem_raddr = next_addr;
		end
	end

	bls_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(val_q),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Status towards the controller.
	always_comb begin
		sts.no_result = (op_q > OP_DUMP) || ((op_q == OP_DUMP) && empty);
		sts.more      = (op_q == OP_DUMP) && !last;
		sts.out_busy  = out_valid_q && out_stall;
	end

	// Control state: count, capacity, dump index and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CAP_W'(CAP_RESET);
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (cmd.exec) begin
				case (op_q)
					OP_PUSH: if (!full) count_q <= count_q + CNT_W'(1);
					OP_POP:  if (!empty) count_q <= count_q - CNT_W'(1);
					OP_DUMP: k_q <= '0;
					default: k_q <= k_q;
				endcase
			end
			if (cmd.emit && sts.more) begin
				k_q <= k_q + K_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item registers, result status and the output payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_item.opcode;
			val_q <= in_item.push_value;
			pos_q <= in_item.position;
		end
		if (cmd.exec) begin
			case (op_q)
				OP_PUSH: res_st_q <= full ? ST_FULL : ST_OK;
				OP_POP:  res_st_q <= empty ? ST_EMPTY : ST_OK;
				OP_PEEK: res_st_q <= empty ? ST_EMPTY : ST_OK;
				OP_READ: res_st_q <= pos_bad ? ST_BADPOS : ST_OK;
				default: res_st_q <= ST_OK;
			endcase
		end
		if (cmd.emit) begin
			out_q.status <= res_st_q;
			if (res_st_q != ST_OK) begin
				out_q.read_value <= '0;
			end else if (op_q == OP_PUSH) begin
				out_q.read_value <= val_q;
			end else begin
				out_q.read_value <= mem_rdata;
			end
			out_q.last_of_run <= (op_q == OP_DUMP) ? last : 1'b1;
			out_q.is_empty    <= empty;
			out_q.is_full     <= full;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// The count never passes the storage depth.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(DEPTH))
		else $error("entry count beyond depth");

	// A successful push grows the stack by one entry.
	a_push_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && (op_q == OP_PUSH) && !full) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("push did not grow the stack");

	// A failed operation reports a zero word.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status != ST_OK)) |-> (out_q.read_value == '0))
		else $error("error result carries a word");

endmodule
`default_nettype wire

>>> design/bounded_lifo_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// Bounded last-in-first-out stack of signed words with push, pop, peek,
// positional read and dump, built from a controller and a datapath.
//
//   Channel   Direction  Handshake              Carries
//   in        into       in_valid / in_stall    in_item (opcode, word, position)
//   out       out of     out_valid / out_stall  out_item (status, word, flags)
//   cfg       into       cfg_wr_en              cfg_wr_data (capacity in use)
//
// An item is taken, executed with one memory access in the next cycle, and
// its result is loaded into the output register in the emit state, once the
// output side is free. No new item is taken until every result of the last
// one is emitted; a dump reads each further entry while emitting one.
// The output register lets the next item be taken while a result waits.
// A stalled output holds the controller in its emit state until taken.
// Reset empties the stack and sets the capacity to eight; no clearing pass.
// ----------------------------------------------------------------------------
module bounded_lifo_stack (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire bls_pkg::in_item_t           in_item,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output bls_pkg::out_item_t               out_item,
	input  wire logic                        cfg_wr_en,
	input  wire logic [bls_pkg::CAP_W-1:0]   cfg_wr_data
);
	import bls_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// Sequencing.
	bls_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Storage and result formation.
	bls_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_item    (in_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd        (cmd),
		.sts        (sts),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_item   (out_item)
	);

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded stack. A driver feeds items from a
// queue that the stimulus process fills, and a monitor predicts the results
// of each accepted item and checks every result against the oldest one.
// Directed cases cover the empty, full and bad-position responses and the
// field extremes; random phases then sweep the capacity register, including
// out-of-range values and capacities below the current fill.
// ----------------------------------------------------------------------------
module tb_top;
	import bls_pkg::*;

	localparam int QUIET_LIMIT    = 2000;
	localparam int PHASE_ITEMS    = 40;
	localparam int HOLD_CYCLES    = 60;
	localparam int IDLE_PCT       = 19;
	localparam int REPORT_LIMIT   = 10;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	in_item_t              in_item     = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	out_item_t             out_item;
	logic                  cfg_wr_en   = 1'b0;
	logic [CAP_W-1:0]      cfg_wr_data = '0;

	// Items waiting to be offered, and results still owed by the block.
	in_item_t              pending_ops[$];
	out_item_t             expected_results[$];

	// Model of the stack contents and the capacity register.
	logic signed [WORD_W-1:0] stack_words [DEPTH];
	int                    word_count   = 0;
	logic [CAP_W-1:0]      capacity_reg = CAP_W'(CAP_RESET);

	logic                  in_fire     = 1'b0;
	logic                  no_idle     = 1'b0;
	logic                  hold_go     = 1'b0;
	logic                  hold_done   = 1'b0;
	int                    hold_left   = 0;
	int                    quiet_cycles = 0;
	int                    error_count = 0;

	bounded_lifo_stack DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Capacity as the block applies it: zero acts as one, and anything above
	// the storage depth acts as the depth.
	function automatic int effective_capacity();
		int cap;
		cap = int'(capacity_reg);
		if (cap < 1)
			cap = 1;
		if (cap > DEPTH)
			cap = DEPTH;
		return cap;
	endfunction

	// Queue one expected result, with the flags as they stand after the step.
	function automatic void add_result(input logic [1:0] status,
			input logic signed [WORD_W-1:0] value, input logic last);
		out_item_t r;
		r.status      = status;
		r.read_value  = value;
		r.last_of_run = last;
		r.is_empty    = (word_count == 0);
		r.is_full     = (word_count >= effective_capacity());
		expected_results.push_back(r);
	endfunction

	// Apply one accepted item to the stack model and record its results.
	function automatic void predict_stack_op(input in_item_t op);
		int n;
		int pos;
		n   = 0;
		pos = int'(op.position);
		case (op.opcode)
			OP_PUSH: begin
				if (word_count >= effective_capacity() || word_count >= DEPTH) begin
					add_result(ST_FULL, '0, 1'b1);
				end else begin
					stack_words[word_count] = op.push_value;
					word_count++;
					add_result(ST_OK, op.push_value, 1'b1);
				end
			end
			OP_POP: begin
				if (word_count == 0) begin
					add_result(ST_EMPTY, '0, 1'b1);
				end else begin
					word_count--;
					add_result(ST_OK, stack_words[word_count], 1'b1);
				end
			end
			OP_PEEK: begin
				if (word_count == 0)
					add_result(ST_EMPTY, '0, 1'b1);
				else
					add_result(ST_OK, stack_words[word_count-1], 1'b1);
			end
			OP_READ: begin
				if (pos < 1 || pos > word_count)
					add_result(ST_BADPOS, '0, 1'b1);
				else
					add_result(ST_OK, stack_words[word_count-pos], 1'b1);
			end
			OP_DUMP: begin
				n = (word_count > MAX_RESULTS) ? MAX_RESULTS : word_count;
				for (int k = 0; k < n; k++)
					add_result(ST_OK, stack_words[word_count-1-k], k == n - 1);
			end
			default: begin
				// Unused opcodes are ignored by the block.
			end
		endcase
	endfunction

	// Compare one accepted result with the oldest expectation.
	function automatic void check_result(input out_item_t got);
		out_item_t want;
		if (expected_results.size() == 0) begin
			error_count++;
			if (error_count <= REPORT_LIMIT)
				$display("[%0t] unexpected result: status %0d value %0d last %0b",
					$realtime, got.status, got.read_value, got.last_of_run);
			return;
		end
		want = expected_results.pop_front();
		if (got.status !== want.status || got.read_value !== want.read_value ||
				got.last_of_run !== want.last_of_run || got.is_empty !== want.is_empty ||
				got.is_full !== want.is_full) begin
			error_count++;
			if (error_count <= REPORT_LIMIT) begin
				$display("[%0t] mismatch: expected st %0d val %0d last %0b emp %0b full %0b",
					$realtime, want.status, want.read_value, want.last_of_run,
					want.is_empty, want.is_full);
				$display("[%0t]           got      st %0d val %0d last %0b emp %0b full %0b",
					$realtime, got.status, got.read_value, got.last_of_run,
					got.is_empty, got.is_full);
			end
		end
	endfunction

	// Monitor: samples every handshake at the rising edge, keeps the model
	// in step and watches for a stuck block.
	always @(posedge clk) begin
		in_fire <= in_valid && !in_stall;
		if (arst_n) begin
			if (cfg_wr_en)
				capacity_reg = cfg_wr_data;
			if (in_valid && !in_stall)
				predict_stack_op(in_item);
			if (out_valid && !out_stall)
				check_result(out_item);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[%0t] no handshake for %0d cycles", $realtime, QUIET_LIMIT);
				$display("** bounded_lifo_stack: FAILED **");
				$finish;
			end
		end
	end

	// Driver: offers the next queued item at the falling edge, holding an
	// item until it has been accepted.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_fire) begin
			// Item still on offer; leave it untouched.
		end else if (pending_ops.size() != 0 &&
				(no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
			in_item  <= pending_ops.pop_front();
			in_valid <= 1'b1;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: random stalls, plus one long hold-off so that the block fills.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	task automatic queue_op(input logic [2:0] opcode, input logic [WORD_W-1:0] value,
			input logic [POS_W-1:0] position);
		in_item_t it;
		it.opcode     = opcode;
		it.push_value = value;
		it.position   = position;
		pending_ops.push_back(it);
	endtask

	// Random item with a given share of pushes; a few use unused opcodes.
	function automatic in_item_t random_stack_op(input int push_pct);
		in_item_t it;
		int roll;
		it.push_value = $urandom();
		if ($urandom_range(0, 15) == 0) begin
			case ($urandom_range(0, 3))
				0:       it.push_value = 32'sh7FFF_FFFF;
				1:       it.push_value = 32'sh8000_0000;
				2:       it.push_value = '0;
				default: it.push_value = '1;
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			it.position = POS_W'($urandom_range(0, 15));
		else
			it.position = POS_W'($urandom_range(0, 9));
		roll = $urandom_range(0, 99);
		if (roll < push_pct) begin
			it.opcode = OP_PUSH;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 3)
				it.opcode = 3'($urandom_range(int'(OP_DUMP) + 1, 7));
			else if (roll < 38)
				it.opcode = OP_POP;
			else if (roll < 53)
				it.opcode = OP_PEEK;
			else if (roll < 78)
				it.opcode = OP_READ;
			else
				it.opcode = OP_DUMP;
		end
		return it;
	endfunction

	// Wait until every queued item has gone in and every result has come out,
	// then give items that cause no result time to clear the block.
	task automatic wait_drained(input int settle);
		while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		@(negedge clk);
		cfg_wr_data <= value;
		cfg_wr_en   <= 1'b1;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		@(posedge clk);
	endtask

	// Stimulus: directed cases first, then random phases over the capacities.
	initial begin
		logic [CAP_W-1:0] phase_cap [8];
		int               phase_push [8];
		phase_cap  = '{4'd8, 4'd2, 4'd0, 4'd15, 4'd1, 4'd9, 4'd5, 4'd3};
		phase_push = '{70, 30, 45, 75, 50, 60, 40, 45};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stack responses at the reset capacity, then the word extremes.
		queue_op(OP_POP, 32'h1234_5678, 4'd0);
		queue_op(OP_PEEK, '0, 4'd1);
		queue_op(OP_READ, '0, 4'd1);
		queue_op(OP_DUMP, '0, 4'd0);
		queue_op(3'd7, '1, 4'd15);
		queue_op(OP_PUSH, 32'h7FFF_FFFF, 4'd0);
		queue_op(OP_PUSH, 32'h8000_0000, 4'd15);
		queue_op(OP_PUSH, 32'h0000_0000, 4'd0);
		queue_op(OP_PUSH, 32'hFFFF_FFFF, 4'd0);
		queue_op(OP_PEEK, '0, 4'd0);
		queue_op(OP_READ, '0, 4'd1);
		queue_op(OP_READ, '0, 4'd4);
		queue_op(OP_READ, '0, 4'd0);
		queue_op(OP_READ, '0, 4'd5);
		queue_op(OP_READ, '0, 4'd15);
		queue_op(OP_DUMP, '0, 4'd0);
		queue_op(3'd5, 32'hA5A5_5A5A, 4'd3);
		queue_op(OP_POP, '0, 4'd0);
		queue_op(OP_POP, '0, 4'd0);
		wait_drained(8);

		// Capacity below the fill: pushes refused until enough pops.
		write_capacity(4'd1);
		queue_op(OP_PUSH, 32'h0BAD_F00D, 4'd0);
		queue_op(OP_DUMP, '0, 4'd0);
		queue_op(OP_POP, '0, 4'd0);
		queue_op(OP_POP, '0, 4'd0);
		queue_op(OP_POP, '0, 4'd0);
		queue_op(OP_PUSH, 32'h0000_0001, 4'd0);
		queue_op(OP_PUSH, 32'h0000_0002, 4'd0);
		wait_drained(8);

		// Random phases, each at its own capacity setting.
		for (int p = 0; p < 8; p++) begin
			write_capacity(phase_cap[p]);
			no_idle = (p == 3);
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_ops.push_back(random_stack_op(phase_push[p]));
			if (p == 0)
				hold_go = 1'b1;
			wait_drained(8);
		end
		no_idle = 1'b0;

		wait_drained(10);
		if (error_count == 0 && expected_results.size() == 0)
			$display("** bounded_lifo_stack: PASSED **");
		else
			$display("** bounded_lifo_stack: FAILED **");
		$finish;
	end

endmodule

>>> files.f
design/bls_pkg.sv
design/bls_ram.sv
design/bls_ctrl.sv
design/bls_dp.sv
design/bounded_lifo_stack.sv
bench/tb_top.sv
